// ===== design/lcdseq_pkg.sv =====
// shared types, codes and constant tables of the character-lcd command sequencer
`default_nettype none
package lcdseq_pkg;

  // command codes of the input channel
  typedef enum logic [3:0] {
    ACT_INIT      = 4'd0,
    ACT_CLEAR     = 4'd1,
    ACT_HOME      = 4'd2,
    ACT_PUT_CHAR  = 4'd3,
    ACT_GOTO      = 4'd4,
    ACT_BACKLIGHT = 4'd5,
    ACT_CURSOR    = 4'd6,
    ACT_BLINK     = 4'd7,
    ACT_DISPLAY   = 4'd8,
    ACT_SHIFT_L   = 4'd9,
    ACT_SHIFT_R   = 4'd10,
    ACT_GLYPH     = 4'd11
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LINES   = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_ADDRESS = 2'd2
  } cfg_reg_t;

  // kind of work handed from front to back
  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_INSTR,
    JOB_DATA,
    JOB_LED
  } job_kind_t;

  // back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  cmd;       // instruction/data byte, function-set byte for init
    logic [15:0] wait_end;  // wait after the final write of the low nibble
    logic        led_on;
  } job_t;

  typedef struct packed {
    logic [2:0] lines;
    logic [5:0] columns;
    logic [6:0] address;
  } cfg_t;

  localparam int QDEPTH = 2;

  // expander pin positions
  localparam int PIN_RS  = 0;
  localparam int PIN_RW  = 1;
  localparam int PIN_E   = 2;
  localparam int PIN_LED = 3;

  // instruction bytes
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_ENTRY   = 8'h06;
  localparam logic [7:0] CMD_FSET_1L = 8'h20;
  localparam logic [7:0] CMD_FSET_2L = 8'h28;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] CMD_DISP_ON = 8'h0C;
  localparam logic [7:0] CMD_DISP_OFF = 8'h08;
  localparam logic [7:0] CMD_CURSOR  = 8'h0E;
  localparam logic [7:0] CMD_BLINK   = 8'h0D;
  localparam logic [7:0] CMD_SHIFT_L = 8'h18;
  localparam logic [7:0] CMD_SHIFT_R = 8'h1C;

  // ddram row offsets
  localparam logic [7:0] ROW_OFF_0 = 8'h00;
  localparam logic [7:0] ROW_OFF_1 = 8'h40;
  localparam logic [7:0] ROW_OFF_2 = 8'h14;
  localparam logic [7:0] ROW_OFF_3 = 8'h54;

  // waits in microseconds
  localparam logic [15:0] WAIT_LED_US   = 16'd0;
  localparam logic [15:0] WAIT_NIB_US   = 16'd10;
  localparam logic [15:0] WAIT_INSTR_US = 16'd100;
  localparam logic [15:0] WAIT_DATA_US  = 16'd150;
  localparam logic [15:0] WAIT_GOTO_US  = 16'd200;
  localparam logic [15:0] WAIT_INIT1_US = 16'd250;
  localparam logic [15:0] WAIT_LONG_US  = 16'd2100;
  localparam logic [15:0] WAIT_INIT0_US = 16'd5100;

  localparam logic [3:0] INIT_LAST_NIB = 4'd13;
  localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

  // nibble sequence of the power-on init
  function automatic logic [3:0] init_nibble(input logic [3:0] idx, input logic [7:0] fset);
    logic [3:0] nib;
    begin
      unique case (idx)
        4'd0, 4'd1, 4'd2: nib = 4'h3;
        4'd3:             nib = 4'h2;
        4'd4:             nib = fset[7:4];
        4'd5:             nib = fset[3:0];
        4'd6:             nib = fset[7:4];
        4'd7:             nib = fset[3:0];
        4'd8:             nib = CMD_DISP_ON[7:4];
        4'd9:             nib = CMD_DISP_ON[3:0];
        4'd10:            nib = CMD_ENTRY[7:4];
        4'd11:            nib = CMD_ENTRY[3:0];
        4'd12:            nib = CMD_CLEAR[7:4];
        4'd13:            nib = CMD_CLEAR[3:0];
        default:          nib = 4'h0;
      endcase
      return nib;
    end
  endfunction

  // wait after the last write of each init nibble
  function automatic logic [15:0] init_wait(input logic [3:0] idx);
    logic [15:0] w;
    begin
      unique case (idx)
        4'd0:          w = WAIT_INIT0_US;
        4'd1:          w = WAIT_INIT1_US;
        4'd2:          w = WAIT_DATA_US;
        INIT_LAST_NIB: w = WAIT_LONG_US;
        default:       w = WAIT_INSTR_US;
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/lcdseq_chan_if.sv =====
// channel interfaces: command input, expander write output, configuration writes
`default_nettype none
interface lcdseq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] char_byte;
  logic [5:0] column;
  logic [1:0] row;
  logic [2:0] glyph_slot;
  logic       switch_on;
  modport source (output valid, action, char_byte, column, row, glyph_slot, switch_on,
                  input ready);
  modport sink (input valid, action, char_byte, column, row, glyph_slot, switch_on,
                output ready);
endinterface

interface lcdseq_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  expander_byte;
  logic [6:0]  target_address;
  logic [15:0] wait_after_us;
  logic        last_write;
  modport source (output valid, expander_byte, target_address, wait_after_us, last_write,
                  input ready);
  modport sink (input valid, expander_byte, target_address, wait_after_us, last_write,
                output ready);
endinterface

interface lcdseq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/char_lcd_nibble_command_sequencer.sv =====
// top level: configuration registers, front end, job queue and write sequencer
//
// Drives a 4-bit character LCD through an 8-bit I2C port expander.
// in_chan takes one command per transaction (init, clear, home, put_char, goto,
// backlight, cursor, blink, display, shift, glyph address). out_chan gives the
// expander writes of each command in order, each with bus address, minimum
// wait after it and a flag on the final write of the command.
// cfg_chan writes display_lines (index 0), display_columns (1) and
// expander_address (2); it is always ready and is meant for idle periods.
// The first write of a command passes through the job queue, the job register
// and the output register to out_chan. Throughput: one write per cycle from the
// output register while out_chan is ready; a command has six writes for an
// instruction or character, one for backlight, 42 for init. Commands that
// emit nothing (unused codes, goto off the panel) are taken and dropped.
// A two-entry job queue lets the input keep taking commands while out_chan
// is stalled; when the queue is full in_chan.ready drops. A stalled write
// holds on out_chan until taken.
// Reset: registers return to two lines, sixteen columns, address 39, pin
// image all low, queue empty.
`default_nettype none
module char_lcd_nibble_command_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  lcdseq_in_if.sink     in_chan,
  lcdseq_out_if.source  out_chan,
  lcdseq_cfg_if.sink    cfg_chan
);
  import lcdseq_pkg::*;

  cfg_t cfg_r;
  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic job_valid;
  logic job_pop;
  job_t job;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lines   <= 3'd2;
      cfg_r.columns <= 6'd16;
      cfg_r.address <= 7'd39;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_LINES:   cfg_r.lines   <= cfg_chan.data[2:0];
        REG_COLUMNS: cfg_r.columns <= cfg_chan.data[5:0];
        REG_ADDRESS: cfg_r.address <= cfg_chan.data[6:0];
        default:     ;
      endcase
    end
  end

  lcdseq_front u_front (
    .in_chan      (in_chan),
    .cfg_i        (cfg_r),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  lcdseq_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_pop),
    .pop_job_o    (job)
  );

  lcdseq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .out_chan    (out_chan)
  );

  // rw pin is never driven high
  a_rw_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !out_chan.expander_byte[PIN_RW])
    else $error("rw pin set on an expander write");

  // an enable-high write is always followed by the short strobe wait
  a_e_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.expander_byte[PIN_E]) |->
      (out_chan.wait_after_us == WAIT_NIB_US && !out_chan.last_write))
    else $error("enable-high write with wrong wait or marked last");

  // only the single backlight write has no wait, and it closes its command
  a_led_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.wait_after_us == WAIT_LED_US) |-> out_chan.last_write)
    else $error("zero-wait write not marked last");

  // a job is only popped when the queue holds one
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("sequencer popped an empty queue");

endmodule
`default_nettype wire

// ===== design/lcdseq_front.sv =====
// front end: accepts commands and turns each into a job for the write sequencer
`default_nettype none
module lcdseq_front (
  lcdseq_in_if.sink         in_chan,
  input  lcdseq_pkg::cfg_t  cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output lcdseq_pkg::job_t  push_job_o
);
  import lcdseq_pkg::*;

  logic       emits;
  logic       goto_ok;
  logic [7:0] row_off;
  logic [7:0] goto_cmd;
  logic [7:0] fset;

  // goto bounds and ddram address
  always_comb begin
    goto_ok = ({1'b0, in_chan.row} < cfg_i.lines) && (in_chan.column < cfg_i.columns);
    if (cfg_i.lines <= 3'd2) begin
      row_off = (in_chan.row == 2'd0) ? ROW_OFF_0 : ROW_OFF_1;
    end else begin
      case (in_chan.row)
        2'd0:    row_off = ROW_OFF_0;
        2'd1:    row_off = ROW_OFF_1;
        2'd2:    row_off = ROW_OFF_2;
        default: row_off = ROW_OFF_3;
      endcase
    end
    goto_cmd = (CMD_DDRAM | row_off) + {2'b00, in_chan.column};
    fset     = (cfg_i.lines > 3'd1) ? CMD_FSET_2L : CMD_FSET_1L;
  end

  // command decode
  always_comb begin
    emits               = 1'b1;
    push_job_o.kind     = JOB_INSTR;
    push_job_o.cmd      = 8'h00;
    push_job_o.wait_end = WAIT_INSTR_US;
    push_job_o.led_on   = in_chan.switch_on;
    unique case (action_t'(in_chan.action))
      ACT_INIT: begin
        push_job_o.kind = JOB_INIT;
        push_job_o.cmd  = fset;
      end
      ACT_CLEAR: begin
        push_job_o.cmd      = CMD_CLEAR;
        push_job_o.wait_end = WAIT_LONG_US;
      end
      ACT_HOME: begin
        push_job_o.cmd      = CMD_HOME;
        push_job_o.wait_end = WAIT_LONG_US;
      end
      ACT_PUT_CHAR: begin
        push_job_o.kind     = JOB_DATA;
        push_job_o.cmd      = in_chan.char_byte;
        push_job_o.wait_end = WAIT_DATA_US;
      end
      ACT_GOTO: begin
        emits               = goto_ok;
        push_job_o.cmd      = goto_cmd;
        push_job_o.wait_end = WAIT_GOTO_US;
      end
      ACT_BACKLIGHT: begin
        push_job_o.kind     = JOB_LED;
        push_job_o.wait_end = WAIT_LED_US;
      end
      ACT_CURSOR:  push_job_o.cmd = in_chan.switch_on ? CMD_CURSOR : CMD_DISP_ON;
      ACT_BLINK:   push_job_o.cmd = in_chan.switch_on ? CMD_BLINK : CMD_DISP_ON;
      ACT_DISPLAY: push_job_o.cmd = in_chan.switch_on ? CMD_DISP_ON : CMD_DISP_OFF;
      ACT_SHIFT_L: push_job_o.cmd = CMD_SHIFT_L;
      ACT_SHIFT_R: push_job_o.cmd = CMD_SHIFT_R;
      ACT_GLYPH:   push_job_o.cmd = {2'b01, in_chan.glyph_slot, 3'b000};
      default:     emits = 1'b0;
    endcase
  end

  // commands that emit nothing are taken and dropped
  assign in_chan.ready = push_ready_i;
  assign push_valid_o  = in_chan.valid && emits;

endmodule
`default_nettype wire

// ===== design/lcdseq_queue.sv =====
// two-entry job queue between the front end and the write sequencer
`default_nettype none
module lcdseq_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  lcdseq_pkg::job_t  push_job_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output lcdseq_pkg::job_t  pop_job_o
);
  import lcdseq_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = (count_r != (PW+1)'(QDEPTH));
  assign pop_valid_o  = (count_r != '0);
  assign pop_job_o    = slot_r[rd_ptr_r];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lcdseq_back.sv =====
// back end: plays each job out as expander writes and keeps the pin image
`default_nettype none
module lcdseq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  lcdseq_pkg::cfg_t  cfg_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  lcdseq_pkg::job_t  job_i,
  lcdseq_out_if.source      out_chan
);
  import lcdseq_pkg::*;

  bk_state_t   state_r, state_nxt;
  job_t        job_r;
  logic [3:0]  nib_idx_r, nib_idx_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  image_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic [6:0]  out_addr_r;
  logic [15:0] out_wait_r;
  logic        out_last_r;

  logic        adv;
  logic        step;
  logic [3:0]  nib;
  logic [7:0]  wr_byte;
  logic [15:0] wr_wait;
  logic        wr_last;

  // output slot free
  assign adv  = !out_valid_r || out_chan.ready;
  assign step = (state_r == BK_RUN) && adv;

  // current write
  always_comb begin
    if (job_r.kind == JOB_INIT) begin
      nib = init_nibble(nib_idx_r, job_r.cmd);
    end else begin
      nib = nib_idx_r[0] ? job_r.cmd[3:0] : job_r.cmd[7:4];
    end
    wr_byte = {nib, image_r[PIN_LED], (phase_r == 2'd1), 1'b0, (job_r.kind == JOB_DATA)};
    if (phase_r != 2'd2) begin
      wr_wait = WAIT_NIB_US;
    end else if (job_r.kind == JOB_INIT) begin
      wr_wait = init_wait(nib_idx_r);
    end else begin
      wr_wait = (nib_idx_r == 4'd0) ? WAIT_INSTR_US : job_r.wait_end;
    end
    wr_last = (phase_r == 2'd2) &&
              (nib_idx_r == ((job_r.kind == JOB_INIT) ? INIT_LAST_NIB : BYTE_LAST_NIB));
    if (job_r.kind == JOB_LED) begin
      wr_byte = {image_r[7:4], job_r.led_on, image_r[2:0]};
      wr_wait = job_r.wait_end;
      wr_last = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid_i) state_nxt = BK_RUN;
      BK_RUN:  if (step && wr_last && !job_valid_i) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // sequencer outputs: pop the next job when idle or at the final write
  always_comb begin
    job_pop_o = 1'b0;
    unique case (state_r)
      BK_IDLE: job_pop_o = job_valid_i;
      BK_RUN:  job_pop_o = step && wr_last && job_valid_i;
      default: job_pop_o = 1'b0;
    endcase
  end

  // nibble and phase counters
  always_comb begin
    nib_idx_nxt = nib_idx_r;
    phase_nxt   = phase_r;
    if (job_pop_o) begin
      nib_idx_nxt = '0;
      phase_nxt   = '0;
    end else if (step) begin
      if (phase_r == 2'd2) begin
        phase_nxt   = '0;
        nib_idx_nxt = nib_idx_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop_o) begin
      job_r <= job_i;
    end
    if (step) begin
      out_byte_r <= wr_byte;
      out_addr_r <= cfg_i.address;
      out_wait_r <= wr_wait;
      out_last_r <= wr_last;
    end
  end

  // control state and pin image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      nib_idx_r   <= '0;
      phase_r     <= '0;
      image_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      nib_idx_r <= nib_idx_nxt;
      phase_r   <= phase_nxt;
      if (step) begin
        image_r     <= wr_byte;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.expander_byte  = out_byte_r;
  assign out_chan.target_address = out_addr_r;
  assign out_chan.wait_after_us  = out_wait_r;
  assign out_chan.last_write     = out_last_r;

endmodule
`default_nettype wire
